// ===== hw/rtl/sorted_list_merge_split_core_assert.svh =====
// Assertion macros for the merge-split core checker.
// Expects i_clk and i_rst_n (synchronous, active low) in the using scope.
`ifndef SORTED_LIST_MERGE_SPLIT_CORE_ASSERT_SVH
`define SORTED_LIST_MERGE_SPLIT_CORE_ASSERT_SVH

// Plain clocked property, disabled while reset is held.
`define SLMS_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("slms checker: property failed");

// A signal group holds in the cycle after a condition.
`define SLMS_ASSERT_HOLD(lbl, cond, sig) \
    `SLMS_ASSERT_CLK(lbl, (cond) |=> $stable(sig))

`endif

// ===== hw/rtl/slms_pkg.sv =====
// Shared widths, register indexes and the run command struct of the merge-split core.
// No dependencies.
`default_nettype none

package slms_pkg;

    localparam int KEY_W      = 64;
    localparam int PAY_W      = 64;
    localparam int ENT_W      = KEY_W + PAY_W;   // {key, payload}
    localparam int LEN_W      = 7;               // list_length register width
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_HIGH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH = 4'd1;

    // run command from the load controller to the merge and emit units
    typedef struct packed {
        logic             merge_go;   // one-cycle pulse: start merging
        logic             emit_go;    // one-cycle pulse: start emitting
        logic             keep_high;  // mode sampled at run end
        logic [LEN_W-1:0] len;        // clamped run length, 1..min(MAX_LEN, 127)
    } t_run_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/slms_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module slms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slms_merge.sv =====
// Merge sequencer: walks the own and partner list RAMs from the front or the back
// and writes one merged entry per cycle into the result RAM. Uses slms_pkg.
`default_nettype none

module slms_merge #(
    parameter int AW = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire slms_pkg::t_run_cmd        i_cmd,
    input  wire logic [slms_pkg::ENT_W-1:0] i_own_rdata,
    input  wire logic [slms_pkg::ENT_W-1:0] i_par_rdata,
    output logic                           o_list_re,
    output logic [AW-1:0]                  o_own_raddr,
    output logic [AW-1:0]                  o_par_raddr,
    output logic                           o_res_we,
    output logic [AW-1:0]                  o_res_waddr,
    output logic [slms_pkg::ENT_W-1:0]     o_res_wdata,
    output logic                           o_done
);

    localparam int LW = slms_pkg::LEN_W;
    localparam int KW = slms_pkg::KEY_W;
    localparam int EW = slms_pkg::ENT_W;
    localparam logic [LW:0]   ONE_W  = {{LW{1'b0}}, 1'b1};
    localparam logic [LW-1:0] ONE_N  = {{(LW-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {S_IDLE, S_PRIME0, S_PRIME1, S_RUN} t_state;

    t_state         r_state;
    logic [LW-1:0]  r_ta;        // entries taken from own list
    logic [LW-1:0]  r_tb;        // entries taken from partner list
    logic [LW-1:0]  r_step;      // result entries written
    logic [EW-1:0]  r_head_own;  // current own candidate
    logic [EW-1:0]  r_head_par;  // current partner candidate

    logic           exh_own;
    logic           exh_par;
    logic           take_own;
    logic           run;
    logic           last_step;
    logic [LW-1:0]  n_ta;
    logic [LW-1:0]  n_tb;
    logic [LW:0]    own_t;
    logic [LW:0]    par_t;

    // list position of the t-th taken entry: front walks up, back walks down
    function automatic logic [LW:0] f_pos(input logic kh, input logic [LW-1:0] len,
                                          input logic [LW:0] t);
        if (kh) begin
            f_pos = {1'b0, len} - ONE_W - t;
        end else begin
            f_pos = t;
        end
    endfunction

    // position to RAM address, zero-extended or truncated to the address width
    function automatic logic [AW-1:0] f_addr(input logic [LW:0] v);
        logic [AW+LW:0] w;
        w = {{AW{1'b0}}, v};
        f_addr = w[AW-1:0];
    endfunction

    // compare the two heads; an exhausted list always loses
    always_comb begin
        run       = (r_state == S_RUN);
        exh_own   = (r_ta == i_cmd.len);
        exh_par   = (r_tb == i_cmd.len);
        if (exh_own) begin
            take_own = 1'b0;
        end else if (exh_par) begin
            take_own = 1'b1;
        end else if (i_cmd.keep_high) begin
            take_own = r_head_own[EW-1 -: KW] >= r_head_par[EW-1 -: KW];
        end else begin
            take_own = r_head_own[EW-1 -: KW] <= r_head_par[EW-1 -: KW];
        end
        n_ta      = r_ta + LW'(run & take_own);
        n_tb      = r_tb + LW'(run & ~take_own);
        last_step = (r_step == i_cmd.len - ONE_N);
    end

    // prefetch: first entries in S_PRIME0, then the entry after the next head
    always_comb begin
        if (r_state == S_PRIME0) begin
            own_t = '0;
            par_t = '0;
        end else begin
            own_t = {1'b0, n_ta} + ONE_W;
            par_t = {1'b0, n_tb} + ONE_W;
        end
        o_list_re   = (r_state != S_IDLE);
        o_own_raddr = f_addr(f_pos(i_cmd.keep_high, i_cmd.len, own_t));
        o_par_raddr = f_addr(f_pos(i_cmd.keep_high, i_cmd.len, par_t));
        o_res_we    = run;
        o_res_waddr = f_addr(f_pos(i_cmd.keep_high, i_cmd.len, {1'b0, r_step}));
        o_res_wdata = take_own ? r_head_own : r_head_par;
        o_done      = run & last_step;
    end

    // sequencer state and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ta    <= '0;
            r_tb    <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.merge_go) begin
                        r_state <= S_PRIME0;
                        r_ta    <= '0;
                        r_tb    <= '0;
                        r_step  <= '0;
                    end
                end
                S_PRIME0: r_state <= S_PRIME1;
                S_PRIME1: r_state <= S_RUN;
                S_RUN: begin
                    r_ta   <= n_ta;
                    r_tb   <= n_tb;
                    r_step <= r_step + ONE_N;
                    if (last_step) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // head registers: loaded at prime, refilled from the prefetched entry
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRIME1) begin
            r_head_own <= i_own_rdata;
            r_head_par <= i_par_rdata;
        end else if (run) begin
            if (take_own) begin
                r_head_own <= i_own_rdata;
            end else begin
                r_head_par <= i_par_rdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slms_emit.sv =====
// Result emitter: reads the result RAM in ascending order and drives the output
// channel, with the RAM read register acting as a skid stage. Uses slms_pkg.
`default_nettype none

module slms_emit #(
    parameter int AW = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire slms_pkg::t_run_cmd          i_cmd,
    input  wire logic [slms_pkg::ENT_W-1:0]  i_res_rdata,
    output logic                             o_res_re,
    output logic [AW-1:0]                    o_res_raddr,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [slms_pkg::KEY_W-1:0]       o_key,
    output logic [slms_pkg::PAY_W-1:0]       o_payload,
    output logic                             o_last,
    output logic                             o_done
);

    localparam int LW = slms_pkg::LEN_W;
    localparam int KW = slms_pkg::KEY_W;
    localparam int PW = slms_pkg::PAY_W;
    localparam logic [LW-1:0] ONE_N = {{(LW-1){1'b0}}, 1'b1};

    logic            r_act;      // reads still to issue
    logic [LW-1:0]   r_cnt;      // next result index to read
    logic            r_rd_vld;   // RAM read register holds an item
    logic            r_rd_last;
    logic            r_valid;
    logic            r_last;
    logic [KW-1:0]   r_key;
    logic [PW-1:0]   r_pay;

    logic            move;
    logic            rd_en;
    logic            cnt_last;
    logic [AW+LW-1:0] addr_ext;

    // two-stage flow: RAM register -> output register
    always_comb begin
        move        = r_rd_vld & (~r_valid | ~i_stall);
        rd_en       = r_act & (~r_rd_vld | move);
        cnt_last    = (r_cnt == i_cmd.len - ONE_N);
        addr_ext    = {{AW{1'b0}}, r_cnt};
        o_res_re    = rd_en;
        o_res_raddr = addr_ext[AW-1:0];
        o_valid     = r_valid;
        o_key       = r_key;
        o_payload   = r_pay;
        o_last      = r_last;
        o_done      = r_valid & ~i_stall & r_last;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            if (i_cmd.emit_go) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + ONE_N;
                if (cnt_last) begin
                    r_act <= 1'b0;
                end
            end
            if (rd_en) begin
                r_rd_last <= cnt_last;
            end
            r_rd_vld <= rd_en | (r_rd_vld & ~move);
            if (move) begin
                r_valid <= 1'b1;
                r_last  <= r_rd_last;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_key <= i_res_rdata[slms_pkg::ENT_W-1 -: KW];
            r_pay <= i_res_rdata[PW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_list_merge_split_core.sv =====
// Merge-split step of a bitonic sort. Items carry element k of two ascending lists
// (own and partner, 64-bit key plus 64-bit payload each); n items load a run, where n
// is list_length clamped to 1..min(MAX_LEN, 127). After the last item the block emits
// n entries in ascending key order: the n smallest of both lists (keep_high = 0) or the
// n largest (keep_high = 1), ties going to the own list. A run passes these steps in
// order: load (one RAM write per item), hand-off of the run to the merge unit, priming
// of the list RAM read ports, merge (one compare and one result RAM write per cycle),
// start of the emitter, result RAM read and output register, then output of the n
// entries. The input channel stalls from the last item of a run until its final
// result is taken. No clearing pass after reset. Uses slms_pkg, slms_ram, slms_merge,
// slms_emit.
`default_nettype none

module sorted_list_merge_split_core #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input items
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [slms_pkg::KEY_W-1:0]           i_own_key,
    input  wire logic [slms_pkg::PAY_W-1:0]           i_own_payload,
    input  wire logic [slms_pkg::KEY_W-1:0]           i_partner_key,
    input  wire logic [slms_pkg::PAY_W-1:0]           i_partner_payload,
    // result items
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [slms_pkg::KEY_W-1:0]                o_key,
    output logic [slms_pkg::PAY_W-1:0]                o_payload,
    output logic                                      o_last,
    // configuration writes
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [slms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [slms_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int LW = slms_pkg::LEN_W;
    localparam int EW = slms_pkg::ENT_W;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LW-1:0] LEN_CAP = (MAX_LEN > 127) ? 7'd127 : LW'(MAX_LEN);
    localparam logic [LW-1:0] ONE_N   = {{(LW-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {S_LOAD, S_MERGE, S_EMIT} t_state;

    t_state              r_state;
    logic                r_keep_high;
    logic [LW-1:0]       r_list_length;
    logic [LW-1:0]       r_load_cnt;
    slms_pkg::t_run_cmd  r_cmd;

    logic [LW-1:0]       run_len;
    logic                in_acc;
    logic [LW:0]         cnt_nx;
    logic                end_run;
    logic                list_we;
    logic [AW+LW-1:0]    wa_ext;
    logic [AW-1:0]       list_waddr;

    logic                list_re;
    logic [AW-1:0]       own_raddr;
    logic [AW-1:0]       par_raddr;
    logic [EW-1:0]       own_rdata;
    logic [EW-1:0]       par_rdata;
    logic                res_we;
    logic [AW-1:0]       res_waddr;
    logic [EW-1:0]       res_wdata;
    logic                res_re;
    logic [AW-1:0]       res_raddr;
    logic [EW-1:0]       res_rdata;
    logic                merge_done;
    logic                emit_done;

    // run length and load bookkeeping
    always_comb begin
        if (r_list_length == '0) begin
            run_len = ONE_N;
        end else if (r_list_length > LEN_CAP) begin
            run_len = LEN_CAP;
        end else begin
            run_len = r_list_length;
        end
        in_acc      = i_valid & (r_state == S_LOAD);
        cnt_nx      = {1'b0, r_load_cnt} + {{LW{1'b0}}, 1'b1};
        end_run     = (cnt_nx >= {1'b0, run_len});
        list_we     = in_acc & (32'(r_load_cnt) < MAX_LEN);
        wa_ext      = {{AW{1'b0}}, r_load_cnt};
        list_waddr  = wa_ext[AW-1:0];
        o_stall     = (r_state != S_LOAD);
        o_cfg_ready = 1'b1;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_high   <= 1'b0;
            r_list_length <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slms_pkg::CFG_KEEP_HIGH:   r_keep_high   <= i_cfg_data[0];
                slms_pkg::CFG_LIST_LENGTH: r_list_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // run controller: load, merge, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_cmd      <= '0;
        end else begin
            // one-cycle start pulses for the merge and emit units
            r_cmd.merge_go <= in_acc & end_run;
            r_cmd.emit_go  <= (r_state == S_MERGE) & merge_done;
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (end_run) begin
                            r_load_cnt      <= '0;
                            r_cmd.keep_high <= r_keep_high;
                            r_cmd.len       <= run_len;
                            r_state         <= S_MERGE;
                        end else begin
                            r_load_cnt <= cnt_nx[LW-1:0];
                        end
                    end
                end
                S_MERGE: begin
                    if (merge_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_done) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // list stores
    slms_ram #(.DEPTH(MAX_LEN), .WIDTH(EW), .AW(AW)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata ({i_own_key, i_own_payload}),
        .i_re    (list_re),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    slms_ram #(.DEPTH(MAX_LEN), .WIDTH(EW), .AW(AW)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata ({i_partner_key, i_partner_payload}),
        .i_re    (list_re),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    // result store
    slms_ram #(.DEPTH(MAX_LEN), .WIDTH(EW), .AW(AW)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_re    (res_re),
        .i_raddr (res_raddr),
        .o_rdata (res_rdata)
    );

    slms_merge #(.AW(AW)) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (r_cmd),
        .i_own_rdata (own_rdata),
        .i_par_rdata (par_rdata),
        .o_list_re   (list_re),
        .o_own_raddr (own_raddr),
        .o_par_raddr (par_raddr),
        .o_res_we    (res_we),
        .o_res_waddr (res_waddr),
        .o_res_wdata (res_wdata),
        .o_done      (merge_done)
    );

    slms_emit #(.AW(AW)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (r_cmd),
        .i_res_rdata (res_rdata),
        .o_res_re    (res_re),
        .o_res_raddr (res_raddr),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_key       (o_key),
        .o_payload   (o_payload),
        .o_last      (o_last),
        .o_done      (emit_done)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/slms_checker.sv =====
// Port-level checker for the merge-split core, bound to the top level.
// Uses slms_pkg and the assertion macros of sorted_list_merge_split_core_assert.svh.
`default_nettype none
`include "sorted_list_merge_split_core_assert.svh"

module slms_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [slms_pkg::KEY_W-1:0]  o_key,
    input wire logic [slms_pkg::PAY_W-1:0]  o_payload,
    input wire logic                        o_last
);

    // a stalled result item stays put
    `SLMS_ASSERT_HOLD(a_out_hold, o_valid && i_stall, {o_valid, o_key, o_payload, o_last})

    // no item loads while results are pending
    `SLMS_ASSERT_CLK(a_no_load_while_emit, o_valid |-> o_stall)

    // the final result of a run is followed by a gap
    `SLMS_ASSERT_CLK(a_gap_after_last, o_valid && !i_stall && o_last |=> !o_valid)

    // a loaded item is never followed at once by a result
    `SLMS_ASSERT_CLK(a_quiet_after_load, i_valid && !o_stall |=> !o_valid)

endmodule

bind sorted_list_merge_split_core slms_checker u_slms_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_key     (o_key),
    .o_payload (o_payload),
    .o_last    (o_last)
);

`default_nettype wire
